// File: hw/rtl/matrix_multiply_row_engine_assert.svh
// ----------------------------------------------------------------------------
// matrix multiply row engine assertion macros
// implication checks on the rising clock edge, masked while reset is high
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ROW_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ROW_ENGINE_ASSERT_SVH

// same-cycle implication
`define MMRE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmre: same-cycle check failed");

// next-cycle implication
`define MMRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmre: next-cycle check failed");

`endif

// File: hw/rtl/mmre_pkg.sv
// ----------------------------------------------------------------------------
// mmre_pkg
// shared sizes, codes and control types of the matrix multiply row engine
// ----------------------------------------------------------------------------
package mmre_pkg;

  // sizes of the stationary b matrix and the accumulator row
  localparam int INNER_MAX = 16;
  localparam int COLS_MAX  = 16;

  localparam int K_W     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int J_W     = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int B_DEPTH = INNER_MAX * COLS_MAX;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  // fixed field widths
  localparam int SIZE_W    = 7;
  localparam int IDX_W     = 6;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_K_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_SIZE = 1'b1;

  // item kinds
  localparam logic KIND_B = 1'b0;
  localparam logic KIND_A = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic           b_wr;       // store the incoming b element
    logic           a_load;     // latch a element, its k and row start
    logic           first;      // row start, accumulate from zero
    logic           rd_issue;   // read b at column j for the mac pipe
    logic [J_W-1:0] j;          // column for mac read or emit
    logic           emit_load;  // load result register from column j
    logic           emit_last;  // last column of the row
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a new value
    logic pipe_busy;  // mac pipe still holds work
  } dp_status_t;

endpackage

// File: hw/rtl/matrix_multiply_row_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_row_engine: c = a x b with b stationary, one shared mac
// a b element is written to the store; an a element makes one b read per column,
// drains the mac pipe and on the last k emits the row; items stall until it is done
// reset: sizes to 16, accumulators to zero, b store undefined until written
// ----------------------------------------------------------------------------
`include "matrix_multiply_row_engine_assert.svh"

module matrix_multiply_row_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  // item channel
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  kind,
  input  logic [mmre_pkg::IDX_W-1:0]            inner_index,
  input  logic [mmre_pkg::IDX_W-1:0]            column_index,
  input  logic signed [mmre_pkg::ELEM_W-1:0]    element_value,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [mmre_pkg::IDX_W-1:0]            out_column,
  output logic signed [mmre_pkg::SUM_W-1:0]     product_sum,
  output logic                                  row_done,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmre_pkg::SIZE_W-1:0]           cfg_data
);

  // the controller sequences columns for the shared mac:
  //   idle  - takes one item per transfer; b elements go straight to the store
  //   mac   - one b read per column; b data and product registered, then the add
  //   flush - waits for the mac pipe to retire its last column
  //   emit  - on the last k, walks the columns into the result register
  // the result register lets a new item enter while a result waits
  mmre_pkg::dp_cmd_t    dp_cmd;
  mmre_pkg::dp_status_t dp_status;

  mmre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .inner_index  (inner_index),
    .column_index (column_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (dp_cmd),
    .status       (dp_status)
  );

  // datapath: b store ram, q4.12 multiply, 40-bit exact accumulation
  mmre_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .inner_index   (inner_index),
    .column_index  (column_index),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_column    (out_column),
    .product_sum   (product_sum),
    .row_done      (row_done)
  );

  // a pending result is never overwritten
  `MMRE_ASSERT_IMPL(a_emit_free, clk, rst, dp_cmd.emit_load, dp_status.out_free)
  // emit reads the accumulators only once the mac pipe is empty
  `MMRE_ASSERT_IMPL(a_emit_quiet, clk, rst, dp_cmd.emit_load, !dp_status.pipe_busy && !dp_cmd.rd_issue)
  // a loaded a element starts its column pass in the next cycle
  `MMRE_ASSERT_NEXT(a_mac_start, clk, rst, dp_cmd.a_load, dp_cmd.rd_issue)
  // no item transfer while the mac pass runs
  `MMRE_ASSERT_IMPL(a_issue_stalled, clk, rst, dp_cmd.rd_issue, item_stall)

endmodule

// File: hw/rtl/mmre_ram.sv
// ----------------------------------------------------------------------------
// mmre_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mmre_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/mmre_datapath.sv
// ----------------------------------------------------------------------------
// mmre_datapath
// b store, shared multiply-accumulate pipe, accumulator row, result register
// ----------------------------------------------------------------------------
module mmre_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mmre_pkg::dp_cmd_t                     cmd,
  output mmre_pkg::dp_status_t                  status,
  input  logic [mmre_pkg::IDX_W-1:0]            inner_index,
  input  logic [mmre_pkg::IDX_W-1:0]            column_index,
  input  logic signed [mmre_pkg::ELEM_W-1:0]    element_value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [mmre_pkg::IDX_W-1:0]            out_column,
  output logic signed [mmre_pkg::SUM_W-1:0]     product_sum,
  output logic                                  row_done
);

  logic [mmre_pkg::K_W-1:0]          k_reg;
  logic signed [mmre_pkg::ELEM_W-1:0] a_reg;
  logic                              first_reg;

  logic [mmre_pkg::B_AW-1:0]         b_wr_addr;
  logic [mmre_pkg::B_AW-1:0]         b_rd_addr;
  logic signed [mmre_pkg::ELEM_W-1:0] b_rdata;

  // pipe: stage 1 has b data, stage 2 has the product
  logic                              v1;
  logic                              v2;
  logic [mmre_pkg::J_W-1:0]          j1;
  logic [mmre_pkg::J_W-1:0]          j2;
  logic signed [mmre_pkg::PROD_W-1:0] p2;

  logic [mmre_pkg::SUM_W-1:0]        acc [mmre_pkg::COLS_MAX];
  logic [mmre_pkg::J_W-1:0]          acc_idx;
  logic [mmre_pkg::SUM_W-1:0]        acc_base;

  assign b_wr_addr = mmre_pkg::B_AW'(inner_index[mmre_pkg::K_W-1:0])
                   * mmre_pkg::B_AW'(mmre_pkg::COLS_MAX)
                   + mmre_pkg::B_AW'(column_index[mmre_pkg::J_W-1:0]);
  assign b_rd_addr = mmre_pkg::B_AW'(k_reg) * mmre_pkg::B_AW'(mmre_pkg::COLS_MAX)
                   + mmre_pkg::B_AW'(cmd.j);

  mmre_ram #(
    .WIDTH (mmre_pkg::ELEM_W),
    .DEPTH (mmre_pkg::B_DEPTH)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (cmd.b_wr),
    .wr_addr (b_wr_addr),
    .wr_data (element_value),
    .rd_en   (cmd.rd_issue),
    .rd_addr (b_rd_addr),
    .rd_data (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.a_load) begin
      k_reg     <= inner_index[mmre_pkg::K_W-1:0];
      a_reg     <= element_value;
      first_reg <= cmd.first;
    end
    j1 <= cmd.j;
    j2 <= j1;
    p2 <= a_reg * b_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_issue;
      v2 <= v1;
    end
  end

  // one read index: emit and accumulate never overlap
  assign acc_idx  = cmd.emit_load ? cmd.j : j2;
  assign acc_base = first_reg ? '0 : acc[acc_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mmre_pkg::COLS_MAX; i++) begin
        acc[i] <= '0;
      end
    end else if (v2) begin
      acc[j2] <= acc_base + mmre_pkg::SUM_W'(p2);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_column  <= mmre_pkg::IDX_W'(cmd.j);
      product_sum <= acc[acc_idx];
      row_done    <= cmd.emit_last;
    end
  end

  assign status.out_free  = !result_valid || !result_stall;
  assign status.pipe_busy = v1 || v2;

endmodule

// File: hw/rtl/mmre_ctrl.sv
// ----------------------------------------------------------------------------
// mmre_ctrl
// size registers and the column sequencer of the row engine
// ----------------------------------------------------------------------------
module mmre_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  kind,
  input  logic [mmre_pkg::IDX_W-1:0]            inner_index,
  input  logic [mmre_pkg::IDX_W-1:0]            column_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmre_pkg::SIZE_W-1:0]           cfg_data,
  output mmre_pkg::dp_cmd_t                     cmd,
  input  mmre_pkg::dp_status_t                  status
);

  mmre_pkg::state_t             state;
  mmre_pkg::state_t             state_next;
  logic [mmre_pkg::SIZE_W-1:0]  k_size;
  logic [mmre_pkg::SIZE_W-1:0]  n_size;
  logic [mmre_pkg::SIZE_W-1:0]  k_eff;
  logic [mmre_pkg::SIZE_W-1:0]  n_eff;
  logic [mmre_pkg::J_W-1:0]     j;
  logic [mmre_pkg::J_W-1:0]     j_next;
  logic                         last_row;
  logic                         last_row_next;
  logic                         accept;
  logic                         j_last;
  logic                         b_in_range;
  logic [mmre_pkg::SIZE_W-1:0]  k_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_size <= mmre_pkg::SIZE_RESET;
      n_size <= mmre_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mmre_pkg::CFG_K_SIZE) begin
        k_size <= cfg_data;
      end
      if (cfg_index == mmre_pkg::CFG_N_SIZE) begin
        n_size <= cfg_data;
      end
    end
  end

  always_comb begin
    priority if (k_size == '0) begin
      k_eff = mmre_pkg::SIZE_W'(1);
    end else if (k_size > mmre_pkg::SIZE_W'(mmre_pkg::INNER_MAX)) begin
      k_eff = mmre_pkg::SIZE_W'(mmre_pkg::INNER_MAX);
    end else begin
      k_eff = k_size;
    end
    priority if (n_size == '0) begin
      n_eff = mmre_pkg::SIZE_W'(1);
    end else if (n_size > mmre_pkg::SIZE_W'(mmre_pkg::COLS_MAX)) begin
      n_eff = mmre_pkg::SIZE_W'(mmre_pkg::COLS_MAX);
    end else begin
      n_eff = n_size;
    end
  end

  assign item_stall = (state != mmre_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign k_in       = mmre_pkg::SIZE_W'(inner_index);
  assign j_last     = (mmre_pkg::SIZE_W'(j) == n_eff - mmre_pkg::SIZE_W'(1));
  assign b_in_range = (k_in < mmre_pkg::SIZE_W'(mmre_pkg::INNER_MAX))
                   && (mmre_pkg::SIZE_W'(column_index)
                       < mmre_pkg::SIZE_W'(mmre_pkg::COLS_MAX));

  always_comb begin
    state_next    = state;
    j_next        = j;
    last_row_next = last_row;
    cmd           = '0;
    cmd.j         = j;
    unique case (state)
      mmre_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind == mmre_pkg::KIND_B) begin
            cmd.b_wr = b_in_range;
          end else if (k_in < k_eff) begin
            cmd.a_load    = 1'b1;
            cmd.first     = (k_in == '0);
            last_row_next = (k_in == k_eff - mmre_pkg::SIZE_W'(1));
            j_next        = '0;
            state_next    = mmre_pkg::ST_MAC;
          end
        end
      end
      mmre_pkg::ST_MAC: begin
        cmd.rd_issue = 1'b1;
        if (j_last) begin
          state_next = mmre_pkg::ST_FLUSH;
        end else begin
          j_next = j + mmre_pkg::J_W'(1);
        end
      end
      mmre_pkg::ST_FLUSH: begin
        if (!status.pipe_busy) begin
          j_next     = '0;
          state_next = last_row ? mmre_pkg::ST_EMIT : mmre_pkg::ST_IDLE;
        end
      end
      mmre_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_last = j_last;
          if (j_last) begin
            state_next = mmre_pkg::ST_IDLE;
          end else begin
            j_next = j + mmre_pkg::J_W'(1);
          end
        end
      end
      default: begin
        state_next = mmre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mmre_pkg::ST_IDLE;
      j        <= '0;
      last_row <= 1'b0;
    end else begin
      state    <= state_next;
      j        <= j_next;
      last_row <= last_row_next;
    end
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: matrix multiply row engine testbench
// fills the stationary b matrix, streams a rows under several size settings
// with random idle and stall, and compares every c element against a
// cycle-free predictor of the accumulator row
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// predictor of the accumulator row plus the queue of c elements still owed
class row_product_board;
  typedef struct {
    bit [5:0]  column;
    bit [39:0] sum;
    bit        last;
  } c_elem_t;

  bit [6:0]  k_size;
  bit [6:0]  n_size;
  bit [15:0] b_store [mmre_pkg::B_DEPTH];
  bit [39:0] row_acc [mmre_pkg::COLS_MAX];
  c_elem_t   pending_sums [$];
  int        errors;

  function void clear();
    int i;
    k_size = mmre_pkg::SIZE_RESET;
    n_size = mmre_pkg::SIZE_RESET;
    for (i = 0; i < mmre_pkg::B_DEPTH; i++) b_store[i] = '0;
    for (i = 0; i < mmre_pkg::COLS_MAX; i++) row_acc[i] = '0;
    pending_sums.delete();
    errors = 0;
  endfunction

  function int unsigned clamp_size(bit [6:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function int unsigned k_eff();
    return clamp_size(k_size, mmre_pkg::INNER_MAX);
  endfunction

  function int unsigned n_eff();
    return clamp_size(n_size, mmre_pkg::COLS_MAX);
  endfunction

  function void write_reg(bit [mmre_pkg::CFG_IDX_W-1:0] idx, bit [6:0] data);
    if (idx == mmre_pkg::CFG_K_SIZE) k_size = data;
    else if (idx == mmre_pkg::CFG_N_SIZE) n_size = data;
  endfunction

  // note one accepted item transfer, queue the c elements it completes
  function void take_item(bit knd, bit [5:0] ki, bit [5:0] ci, bit [15:0] raw);
    int unsigned ke;
    int unsigned ne;
    int unsigned j;
    bit signed [31:0] prod;
    c_elem_t e;
    ke = k_eff();
    ne = n_eff();
    if (knd == mmre_pkg::KIND_B) begin
      if (ki < mmre_pkg::INNER_MAX && ci < mmre_pkg::COLS_MAX)
        b_store[ki * mmre_pkg::COLS_MAX + ci] = raw;
      return;
    end
    if (ki >= ke) return;
    for (j = 0; j < ne; j++) begin
      prod = $signed(raw) * $signed(b_store[ki * mmre_pkg::COLS_MAX + j]);
      row_acc[j] = ((ki == 0) ? 40'd0 : row_acc[j]) + {{8{prod[31]}}, prod};
    end
    if (ki == ke - 1) begin
      for (j = 0; j < ne; j++) begin
        e.column = j[5:0];
        e.sum    = row_acc[j];
        e.last   = (j == ne - 1);
        pending_sums.push_back(e);
      end
    end
  endfunction

  // compare one result transfer with the oldest c element owed
  function void check_sum(bit [5:0] col, bit [39:0] sum, bit last);
    c_elem_t e;
    if (pending_sums.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: unexpected result col %0d sum %0d last %0b",
                 col, $signed(sum), last);
      return;
    end
    e = pending_sums.pop_front();
    if (e.column != col || e.sum != sum || e.last != last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp col %0d sum %0d last %0b, got col %0d sum %0d last %0b",
                 e.column, $signed(e.sum), e.last, col, $signed(sum), last);
    end
  endfunction
endclass

module tb;
  import mmre_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic                       kind;
  logic [IDX_W-1:0]           inner_index;
  logic [IDX_W-1:0]           column_index;
  logic signed [ELEM_W-1:0]   element_value;
  logic                       result_valid;
  logic                       result_stall;
  logic [IDX_W-1:0]           out_column;
  logic signed [SUM_W-1:0]    product_sum;
  logic                       row_done;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [SIZE_W-1:0]          cfg_data;

  // no random idling on either side while set
  bit quiet;

  row_product_board board;

  matrix_multiply_row_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .inner_index  (inner_index),
    .column_index (column_index),
    .element_value(element_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_column   (out_column),
    .product_sum  (product_sum),
    .row_done     (row_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver back-pressure, changed on the falling edge only
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall = !quiet && ($urandom_range(0, 99) < 31);
    end
  end

  // item transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      board.take_item(kind, inner_index, column_index, element_value);
  end

  // result transfers are checked against the oldest owed c element
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_sum(out_column, product_sum, row_done);
  end

  // register writes track into the predictor's copy of the sizes
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      board.write_reg(cfg_index, cfg_data);
  end

  // element values lean on the extremes and zero now and then
  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one item transfer; valid stays high afterwards until the next falling edge
  task automatic send_item(logic knd, logic [5:0] ki, logic [5:0] ci, logic [15:0] ev);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid    = 1'b1;
    kind          = knd;
    inner_index   = ki;
    column_index  = ci;
    element_value = ev;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_a(logic [5:0] ki, logic [15:0] ev);
    send_item(KIND_A, ki, 6'($urandom), ev);
  endtask

  // drop valid and hold off until every owed c element has arrived
  task automatic wait_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sizes change only with the engine idle; the extra wait covers a trailing
  // a element that owes nothing but may still be in the mac pass
  task automatic set_sizes(logic [SIZE_W-1:0] ks, logic [SIZE_W-1:0] ns);
    wait_drained();
    repeat (40) @(posedge clk);
    cfg_write(CFG_K_SIZE, ks);
    cfg_write(CFG_N_SIZE, ns);
  endtask

  // mostly whole rows from k = 0, plus b rewrites, ignored items and
  // rows that start part way in
  task automatic run_mix(int target);
    int done;
    int r;
    int ke;
    int k0;
    int kk;
    logic [5:0] bi;
    logic [5:0] bj;
    done = 0;
    while (done < target) begin
      ke = board.k_eff();
      r  = $urandom_range(0, 99);
      if (r < 70) begin
        for (kk = 0; kk < ke; kk++) send_a(kk[5:0], pick_element());
        done += ke;
      end else if (r < 80) begin
        send_item(KIND_B, 6'($urandom_range(0, INNER_MAX - 1)),
                  6'($urandom_range(0, COLS_MAX - 1)), pick_element());
        done++;
      end else if (r < 88) begin
        // full 6-bit indexes, mostly outside the b store
        bi = 6'($urandom);
        bj = 6'($urandom);
        send_item(KIND_B, bi, bj, pick_element());
        if (bi < INNER_MAX && bj < COLS_MAX) done++;
      end else if (r < 94) begin
        send_a(6'($urandom_range(ke, 63)), pick_element());
      end else if (ke > 1) begin
        k0 = $urandom_range(1, ke - 1);
        for (kk = k0; kk < ke; kk++) send_a(kk[5:0], pick_element());
        done += ke - k0;
      end
    end
  endtask

  initial begin
    int k;
    int j;
    int ph;
    int guard;
    logic [SIZE_W-1:0] ks_list [8];
    logic [SIZE_W-1:0] ns_list [8];

    board = new();
    board.clear();
    quiet         = 1'b0;
    item_valid    = 1'b0;
    kind          = KIND_B;
    inner_index   = '0;
    column_index  = '0;
    element_value = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_K_SIZE;
    cfg_data      = '0;

    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every b entry gets written before any a element can read it
    for (k = 0; k < INNER_MAX; k++)
      for (j = 0; j < COLS_MAX; j++)
        send_item(KIND_B, k[5:0], j[5:0], pick_element());

    // directed: two-deep rows over all 16 columns
    set_sizes(7'd2, 7'd16);
    send_item(KIND_B, 6'd63, 6'd0, 16'h1234);   // b row out of range, dropped
    send_item(KIND_B, 6'd0, 6'd63, 16'h4321);   // b column out of range, dropped
    send_item(KIND_B, 6'd16, 6'd16, 16'h5555);  // both out of range, dropped
    send_item(KIND_B, 6'd0, 6'd0, 16'h8000);
    send_item(KIND_B, 6'd0, 6'd15, 16'h7fff);
    send_item(KIND_B, 6'd1, 6'd0, 16'h8000);
    send_item(KIND_B, 6'd1, 6'd15, 16'h8000);
    send_item(KIND_A, 6'd0, 6'd63, 16'h8000);   // most negative squared
    send_a(6'd1, 16'h8000);
    send_a(6'd1, 16'h7fff);                     // no k = 0 first: adds onto last row
    send_a(6'd2, 16'h7fff);                     // k past k_size, dropped
    send_a(6'd63, 16'h8000);                    // far past k_size, dropped
    send_a(6'd0, 16'h7fff);
    send_a(6'd1, 16'h0000);
    send_a(6'd0, 16'h0000);
    send_a(6'd1, 16'hffff);

    // sizes of zero act as one
    set_sizes(7'd0, 7'd0);
    send_a(6'd0, 16'h8000);
    send_a(6'd1, 16'h7fff);                     // dropped at one-deep rows
    send_a(6'd0, 16'h7fff);

    // random phases over several size settings, the top codes among them
    ks_list = '{7'd16, 7'd127, 7'd1, 7'd16, 7'd3, 7'd64, 7'd0, 7'd0};
    ns_list = '{7'd16, 7'd127, 7'd16, 7'd1, 7'd5, 7'd0, 7'd0, 7'd0};
    ks_list[6] = 7'($urandom_range(0, 127));
    ns_list[6] = 7'($urandom_range(0, 127));
    ks_list[7] = 7'($urandom_range(0, 127));
    ns_list[7] = 7'($urandom_range(0, 127));

    for (ph = 0; ph < 8; ph++) begin
      set_sizes(ks_list[ph], ns_list[ph]);
      // first phase runs back to back with no random idle or stall from the bench
      quiet = (ph == 0);
      if (ph == 2) begin
        // sender holds off mid-phase until the result side is empty
        run_mix(3);
        wait_drained();
        run_mix(3);
      end else begin
        run_mix(6);
      end
      quiet = 1'b0;
    end

    // wind down: everything owed must arrive, then let the pipe settle
    @(negedge clk);
    item_valid = 1'b0;
    guard = 0;
    while (board.pending_sums.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    if (board.errors == 0 && board.pending_sums.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mmre_pkg.sv
hw/rtl/mmre_ram.sv
hw/rtl/mmre_datapath.sv
hw/rtl/mmre_ctrl.sv
hw/rtl/matrix_multiply_row_engine.sv
sim/tb.sv
